/* design/longest_increasing_subsequence_length_assert.svh */
// Assertion macros for the longest increasing subsequence length block.
// Used by the port checker; depends on clk_i and rst_ni in the including scope.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define LISL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LISL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/lisl_pkg.sv */
// Shared types and constants for the longest increasing subsequence length block.
// No dependencies; imported by the search sequencer, the top level and the checker.
package lisl_pkg;

  localparam int unsigned LIS_W            = 7;
  localparam int unsigned MAX_PILES_DEFAULT = 64;
  localparam int unsigned KEY_BITS_DEFAULT  = 32;

  // One result transaction, lis_length in the lowest bits.
  typedef struct packed {
    logic             done_res;
    logic             overflow;
    logic [LIS_W-1:0] lis_length;
  } res_t;

endpackage

/* design/lisl_pile_store.sv */
// Pile top memory: one write port and one registered read port.
// No dependencies; instantiated by the top level.
module lisl_pile_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lisl_search.sv */
// Sequencer and shared compare unit: binary search over the pile tops and write-back.
// Depends on lisl_pkg; drives the pile store ports and hands results to the top level.
module lisl_search import lisl_pkg::*; #(
  parameter int unsigned MAX_PILES = MAX_PILES_DEFAULT,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEFAULT,
  localparam int unsigned CNT_W    = $clog2(MAX_PILES + 1),
  localparam int unsigned IDX_W    = $clog2(MAX_PILES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  logic [KEY_BITS-1:0] mem_rdata_i,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output logic [KEY_BITS-1:0] mem_wdata_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_WRITE  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, n_q, n_d, n_next;
  logic [CNT_W:0] mid_sum;
  logic ovf_q, ovf_d, ovf_next;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic last_q, last_d;
  logic at_end, pile_full, commit;
  logic [CNT_W+LIS_W-1:0] len_ext;

  // The search ended past the last pile in use: a new pile, or an overflow when full.
  assign at_end    = (lo_q == n_q);
  assign pile_full = (n_q == CNT_W'(MAX_PILES));
  assign n_next    = (at_end && !pile_full) ? n_q + 1'b1 : n_q;
  assign ovf_next  = ovf_q | (at_end && pile_full);
  assign commit    = (state_q == ST_WRITE) && res_ready_i;

  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    n_d        = n_q;
    ovf_d      = ovf_q;
    key_d      = key_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d  = key_i;
          last_d = last_i;
          lo_d   = '0;
          if (first_i) begin
            n_d   = '0;
            ovf_d = 1'b0;
            hi_d  = '0;
          end else begin
            hi_d = n_q;
          end
          state_d = (hi_d == '0) ? ST_WRITE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The read data is the top of pile mid_q, requested in the previous cycle.
        if ($signed(mem_rdata_i) < $signed(key_q)) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if (lo_d == hi_d) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (res_ready_i) begin
          n_d     = n_next;
          ovf_d   = ovf_next;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Next probe address is the midpoint of the updated interval.
  assign mid_sum     = {1'b0, lo_d} + {1'b0, hi_d};
  assign mid_d       = mid_sum[CNT_W:1];
  assign mem_raddr_o = mid_d[IDX_W-1:0];

  assign mem_we_o    = commit && !(at_end && pile_full);
  assign mem_waddr_o = lo_q[IDX_W-1:0];
  assign mem_wdata_o = key_q;

  assign len_ext          = {{LIS_W{1'b0}}, n_next};
  assign res_valid_o      = (state_q == ST_WRITE);
  assign res_o.lis_length = len_ext[LIS_W-1:0];
  assign res_o.overflow   = ovf_next;
  assign res_o.done_res   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    last_q <= last_d;
  end

endmodule

/* design/longest_increasing_subsequence_length.sv */
// Longest strictly increasing subsequence length by patience sorting. Each input
// transaction carries one signed key (the low KEY_BITS bits of tdata) and a first flag
// on tuser that empties all piles before the key is placed. The block keeps the top key
// of each pile in a memory, finds the first pile whose top is not less than the key by
// a binary search, and replaces that top, or opens a new pile after the last one in use.
// Exactly one output transaction follows every input: tdata holds the number of piles in
// use (the subsequence length, masked to 7 bits) and an overflow bit that is set once a
// key needed a pile beyond MAX_PILES and stays set until the next first flag; tlast
// copies the input tlast. A key passes through the accept state, then the probes of a
// binary search, one per cycle through the single read port of the pile memory, and
// the write-back state. The block takes one key at a time; a finished result sits in an
// output register, so the next key is accepted while it waits. The pile memory needs no
// clearing after reset, since only piles below the count in use are ever compared.
//
// Depends on lisl_pkg, lisl_search and lisl_pile_store.
module longest_increasing_subsequence_length import lisl_pkg::*; #(
  parameter int unsigned MAX_PILES = MAX_PILES_DEFAULT,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEFAULT,
  localparam int unsigned S_TDATA_W = ((KEY_BITS + 7) / 8) * 8,
  localparam int unsigned IDX_W     = $clog2(MAX_PILES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key, zero padding above
  input  logic                 s_axis_tuser,  // first
  input  logic                 s_axis_tlast,  // last
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // lis_length[6:0], overflow
  output logic                 m_axis_tlast   // done_res
);

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [KEY_BITS-1:0] mem_wdata, mem_rdata;
  logic                res_valid, res_ready;
  res_t                res;
  logic                m_valid_q;
  res_t                m_res_q;

  lisl_search #(
    .MAX_PILES(MAX_PILES),
    .KEY_BITS (KEY_BITS)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .key_i      (s_axis_tdata[KEY_BITS-1:0]),
    .first_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  lisl_pile_store #(
    .DEPTH(MAX_PILES),
    .WIDTH(KEY_BITS)
  ) u_pile_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: a new result may load when the slot is empty or is being taken.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.overflow, m_res_q.lis_length};
  assign m_axis_tlast  = m_res_q.done_res;

endmodule

/* design/lisl_checker.sv */
// Port-level checker for the longest increasing subsequence length block, with its bind.
// Depends on lisl_pkg and longest_increasing_subsequence_length_assert.svh.
`include "longest_increasing_subsequence_length_assert.svh"

module lisl_checker import lisl_pkg::*; #(
  parameter int unsigned MAX_PILES = MAX_PILES_DEFAULT,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEFAULT,
  localparam int unsigned S_TDATA_W = ((KEY_BITS + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [7:0]           m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Once reset has been seen low at an edge, no result is offered at the next edge.
  `LISL_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  // A pending result stays offered, unchanged, until it is taken.
  `LISL_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "result dropped or changed while waiting")

  // A waiting input transaction keeps its fields until it is accepted.
  `LISL_ASSERT(a_in_hold,
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser) && $stable(s_axis_tlast),
    "input changed while waiting")

  // One key at a time: the search keeps the input closed in the cycle after an accept.
  `LISL_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready after accept")

  // Overflow can only be reported while every pile is in use.
  `LISL_ASSERT(a_ovf_full, m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[LIS_W-1:0] == LIS_W'(MAX_PILES), "overflow with free piles")

endmodule

bind longest_increasing_subsequence_length lisl_checker #(
  .MAX_PILES(MAX_PILES),
  .KEY_BITS (KEY_BITS)
) u_lisl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

/* dv/longest_increasing_subsequence_length_test.sv */
// Self-checking testbench for longest_increasing_subsequence_length: patience piles, overflow.
// Drives keys on the input stream, predicts every result, checks the output stream in order.
// Depends on lisl_pkg and the longest_increasing_subsequence_length RTL only.
`timescale 1ns / 100ps

module longest_increasing_subsequence_length_test;
  import lisl_pkg::*;

  localparam int unsigned MAX_PILES = MAX_PILES_DEFAULT;
  localparam int unsigned KEY_W     = KEY_BITS_DEFAULT;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  // Idle time at the end, after every result has come back, to catch stray results.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_KEYS   = 1200;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [KEY_W-1:0] s_axis_tdata = '0;   // key
  logic             s_axis_tuser = 1'b0; // first
  logic             s_axis_tlast = 1'b0; // last
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;        // lis_length[6:0], overflow
  logic             m_axis_tlast;        // done_res

  // Predicted pile state, kept in step with every accepted key.
  logic signed [KEY_W-1:0] pile_tops [MAX_PILES];
  int unsigned             piles_in_use = 0;
  logic                    pile_overflow = 1'b0;

  res_t        expected_lis_q[$];
  int unsigned mismatches = 0;
  int unsigned keys_sent = 0;
  bit          jitter_on = 1'b1;

  longest_increasing_subsequence_length i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Places one key on the predicted piles and returns the result it should produce.
  // The first pile whose top is not less than the key takes it; otherwise a new pile
  // opens, unless all piles are in use, in which case the key is lost and overflow sticks.
  function automatic res_t place_on_piles(logic signed [KEY_W-1:0] key, logic first,
                                          logic last);
    int unsigned pos;
    res_t        r;
    if (first) begin
      piles_in_use  = 0;
      pile_overflow = 1'b0;
    end
    pos = 0;
    while (pos < piles_in_use && pile_tops[pos] < key) pos++;
    if (pos < piles_in_use) begin
      pile_tops[pos] = key;
    end else if (piles_in_use < MAX_PILES) begin
      pile_tops[piles_in_use] = key;
      piles_in_use++;
    end else begin
      pile_overflow = 1'b1;
    end
    r.lis_length = LIS_W'(piles_in_use);
    r.overflow   = pile_overflow;
    r.done_res   = last;
    return r;
  endfunction

  // Sends one key after a random gap, when jitter is on, and records its expected result
  // at the edge where it is accepted. With no gap, tvalid simply stays high.
  task automatic send_key(logic signed [KEY_W-1:0] key, logic first, logic last);
    int unsigned gap;
    gap = jitter_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_lis_q.push_back(place_on_piles(key, first, last));
    keys_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_lis_q.size() != 0) @(posedge clk_i);
  endtask

  // Sends a strictly increasing run of keys starting near the bottom of the key range.
  task automatic send_rising_run(int unsigned count, logic first, logic last);
    logic signed [KEY_W-1:0] key;
    key = KEY_MIN + KEY_W'($urandom_range(0, 1000));
    for (int unsigned i = 0; i < count; i++) begin
      send_key(key, first && i == 0, last && i == count - 1);
      key = key + KEY_W'($urandom_range(1, 1 << 20));
    end
  endtask

  // Key extremes, equal keys, decreasing keys, first and last flags alone and together.
  task automatic test_key_extremes();
    // No first flag here: right after reset the piles must already be empty.
    send_key('0, 1'b0, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b0);
    send_key(KEY_MAX, 1'b0, 1'b0);
    send_key(KEY_MAX, 1'b0, 1'b0);
    send_key(-1, 1'b0, 1'b0);
    send_key('0, 1'b0, 1'b0);
    send_key(1, 1'b0, 1'b1);
    send_key(5, 1'b1, 1'b1);
    send_key(KEY_MAX, 1'b1, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b0);
    send_key(KEY_MIN + 1, 1'b0, 1'b0);
    send_key(KEY_MAX - 1, 1'b0, 1'b0);
    send_key(KEY_MAX, 1'b0, 1'b1);
    // A falling sequence never grows past one pile.
    send_key(3, 1'b1, 1'b0);
    send_key(2, 1'b0, 1'b0);
    send_key(1, 1'b0, 1'b0);
    send_key('0, 1'b0, 1'b1);
    // Keys after a last flag but without a first flag extend the same sequence.
    send_key(10, 1'b0, 1'b1);
    send_key(KEY_MIN, 1'b1, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b1);
  endtask

  // Fills every pile, overflows, and checks that the flag holds until the next first flag.
  task automatic test_pile_overflow();
    jitter_on = 1'b0;
    send_rising_run(MAX_PILES, 1'b1, 1'b1);
    send_key(KEY_MAX, 1'b0, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b0);
    send_key(KEY_MAX, 1'b0, 1'b1);
    jitter_on = 1'b1;
    send_rising_run(MAX_PILES + 6, 1'b1, 1'b0);
    send_key(KEY_MIN, 1'b0, 1'b1);
    wait_for_results();
    send_key('0, 1'b1, 1'b1);
  endtask

  // Random sequences of several kinds, most of them well formed, some with stray flags.
  task automatic test_random_sequences();
    int unsigned             kind;
    int unsigned             len;
    int unsigned             seq_count;
    logic signed [KEY_W-1:0] key;
    logic                    first;
    logic                    last;
    seq_count = 0;
    while (keys_sent < RANDOM_KEYS) begin
      kind      = $urandom_range(0, 3);
      jitter_on = ($urandom_range(0, 3) != 0);
      len       = (kind == 2) ? $urandom_range(20, 90) : $urandom_range(1, 40);
      key       = KEY_MIN + KEY_W'($urandom_range(0, 1000));
      for (int unsigned i = 0; i < len; i++) begin
        case (kind)
          0: key = $urandom;
          1: key = KEY_W'($urandom_range(0, 15)) - 8;
          // Mostly rising keys reach deep into the piles, with some noise mixed in.
          2: key = ($urandom_range(0, 7) == 0) ? $urandom
                                               : key + KEY_W'($urandom_range(1, 1 << 20));
          default: key = (i == 0) ? $urandom : key - KEY_W'($urandom_range(0, 1 << 24));
        endcase
        first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        last  = (i == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
        send_key(key, first, last);
      end
      seq_count++;
      if (seq_count % 10 == 0) wait_for_results();
    end
  endtask

  // Output side: a random stall before each result when jitter is on, then ready until it is taken.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = jitter_on ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Every result transaction is matched against the oldest prediction, field by field.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_lis_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_lis_q.pop_front();
        if (m_axis_tdata[LIS_W-1:0] !== want.lis_length) begin
          $display("%0t: lis_length mismatch, expected %0d, actual %0d",
                   $time, want.lis_length, m_axis_tdata[LIS_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[LIS_W] !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, want.overflow, m_axis_tdata[LIS_W]);
          mismatches++;
        end
        if (m_axis_tlast !== want.done_res) begin
          $display("%0t: done_res mismatch, expected %b, actual %b",
                   $time, want.done_res, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_key_extremes();
    test_pile_overflow();
    test_random_sequences();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/lisl_pkg.sv
design/lisl_pile_store.sv
design/lisl_search.sv
design/longest_increasing_subsequence_length.sv
design/lisl_checker.sv
dv/longest_increasing_subsequence_length_test.sv
